[rtl/sldd_pkg.sv]
package sldd_pkg;

	// APB address width: eight 32-bit registers at byte offsets 0..28.
	localparam int ADDR_W = 5;

	// Register indexes (paddr[4:2]).
	localparam logic [2:0] RI_MAX_LIN    = 3'd0;
	localparam logic [2:0] RI_MAX_TURN   = 3'd1;
	localparam logic [2:0] RI_LIN_ACC    = 3'd2;
	localparam logic [2:0] RI_ANG_ACC    = 3'd3;
	localparam logic [2:0] RI_RPM_LIMIT  = 3'd4;
	localparam logic [2:0] RI_TRACK      = 3'd5;
	localparam logic [2:0] RI_FRONT_SCL  = 3'd6;
	localparam logic [2:0] RI_REAR_SCL   = 3'd7;

	// Register reset values.
	localparam logic [14:0] RST_MAX_LIN   = 15'd1000;
	localparam logic [14:0] RST_MAX_TURN  = 15'd2000;
	localparam logic [15:0] RST_LIN_ACC   = 16'd500;
	localparam logic [15:0] RST_ANG_ACC   = 16'd1000;
	localparam logic [14:0] RST_RPM_LIMIT = 15'd10000;
	localparam logic [11:0] RST_TRACK     = 12'd515;
	localparam logic [20:0] RST_FRONT_SCL = 21'd672924;
	localparam logic [20:0] RST_REAR_SCL  = 21'd845742;

	// Command watchdog, microseconds, and the saturation point of its counter.
	localparam logic [20:0] COMMAND_TIMEOUT_US = 21'd1000000;
	localparam logic [20:0] TIMER_MAX          = 21'h1FFFFF;

	// floor(y / 15625) == (y * RECIP_15625) >> 44 exactly for y < 2^30.
	// Together with a shift by 6 this divides by one million.
	localparam logic [30:0] RECIP_15625 = 31'd1125899907;
	// floor(z / 125) == (z * RECIP_125) >> 30 exactly for z < 2^23.
	// Together with a shift by 4 this divides by two thousand.
	localparam logic [30:0] RECIP_125   = 31'd8589935;

	typedef struct packed {
		logic [14:0] max_linear_speed;
		logic [14:0] max_turn_rate;
		logic [15:0] linear_accel_limit;
		logic [15:0] angular_accel_limit;
		logic [14:0] rpm_limit;
		logic [11:0] track_width_mm;
		logic [20:0] front_rpm_scale;
		logic [20:0] rear_rpm_scale;
	} sldd_cfg_t;

	// Multiplier operand selects.
	typedef enum logic [2:0] {
		OPA_NONE,
		OPA_LIN_ACC,
		OPA_ANG_ACC,
		OPA_T0,
		OPA_T1,
		OPA_ANG_MAG,
		OPA_L_MAG,
		OPA_R_MAG
	} opa_t;

	typedef enum logic [2:0] {
		OPB_NONE,
		OPB_DT,
		OPB_R15625,
		OPB_R125,
		OPB_TRACK,
		OPB_FRONT,
		OPB_REAR
	} opb_t;

	// What a step does with the product of the previous step (or with state).
	typedef enum logic [3:0] {
		CAP_NONE,
		CAP_TICK,
		CAP_Y0,
		CAP_Y1,
		CAP_SLEW_L,
		CAP_SLEW_A,
		CAP_Z,
		CAP_HALF,
		CAP_LR,
		CAP_FL,
		CAP_FR,
		CAP_RL,
		CAP_RR,
		CAP_CMD
	} cap_t;

	typedef enum logic {
		JMP_NONE,
		JMP_IF_CMD
	} jmp_t;

	localparam int UC_DEPTH = 18;
	localparam int PC_W     = $clog2(UC_DEPTH);
	localparam logic [PC_W-1:0] UA_CMD = PC_W'(17);

	typedef struct packed {
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		opa_t            a;
		opb_t            b;
		cap_t            cap;
		logic            last;
		logic            emit;
	} uword_t;

	// Microprogram. A product issued in step n is registered and consumed in step n+1.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{jmp: JMP_NONE, target: '0, a: OPA_NONE, b: OPB_NONE, cap: CAP_NONE,
			last: 1'b0, emit: 1'b0};
		unique case (pc)
		PC_W'(0): begin w.jmp = JMP_IF_CMD; w.target = UA_CMD; end
		PC_W'(1): begin w.a = OPA_LIN_ACC; w.b = OPB_DT; w.cap = CAP_TICK; end
		PC_W'(2): begin w.a = OPA_ANG_ACC; w.b = OPB_DT; w.cap = CAP_Y0; end
		PC_W'(3): begin w.a = OPA_T0; w.b = OPB_R15625; w.cap = CAP_Y1; end
		PC_W'(4): begin w.a = OPA_T1; w.b = OPB_R15625; w.cap = CAP_SLEW_L; end
		PC_W'(5): begin w.cap = CAP_SLEW_A; end
		PC_W'(6): begin w.a = OPA_ANG_MAG; w.b = OPB_TRACK; end
		PC_W'(7): begin w.cap = CAP_Z; end
		PC_W'(8): begin w.a = OPA_T0; w.b = OPB_R125; end
		PC_W'(9): begin w.cap = CAP_HALF; end
		PC_W'(10): begin w.cap = CAP_LR; end
		PC_W'(11): begin w.a = OPA_L_MAG; w.b = OPB_FRONT; end
		PC_W'(12): begin w.a = OPA_R_MAG; w.b = OPB_FRONT; w.cap = CAP_FL; end
		PC_W'(13): begin w.a = OPA_L_MAG; w.b = OPB_REAR; w.cap = CAP_FR; end
		PC_W'(14): begin w.a = OPA_R_MAG; w.b = OPB_REAR; w.cap = CAP_RL; end
		PC_W'(15): begin w.cap = CAP_RR; end
		PC_W'(16): begin w.last = 1'b1; w.emit = 1'b1; end
		PC_W'(17): begin w.cap = CAP_CMD; w.last = 1'b1; end
		default: begin w.last = 1'b1; end
		endcase
		return w;
	endfunction

endpackage

[rtl/sldd_ifs.sv]
interface sldd_item_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] linear_cmd;
	logic signed [15:0] angular_cmd;
	logic        [19:0] elapsed_us;

	modport source (output valid, mode, linear_cmd, angular_cmd, elapsed_us, input ready);
	modport sink (input valid, mode, linear_cmd, angular_cmd, elapsed_us, output ready);
endinterface

interface sldd_rpm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] fl_crpm;
	logic signed [15:0] fr_crpm;
	logic signed [15:0] rl_crpm;
	logic signed [15:0] rr_crpm;

	modport source (output valid, fl_crpm, fr_crpm, rl_crpm, rr_crpm, input ready);
	modport sink (input valid, fl_crpm, fr_crpm, rl_crpm, rr_crpm, output ready);
endinterface

[rtl/sldd_regs.sv]
module sldd_regs
	import sldd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output sldd_cfg_t         cfg
);

	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.max_linear_speed    <= RST_MAX_LIN;
			cfg.max_turn_rate       <= RST_MAX_TURN;
			cfg.linear_accel_limit  <= RST_LIN_ACC;
			cfg.angular_accel_limit <= RST_ANG_ACC;
			cfg.rpm_limit           <= RST_RPM_LIMIT;
			cfg.track_width_mm      <= RST_TRACK;
			cfg.front_rpm_scale     <= RST_FRONT_SCL;
			cfg.rear_rpm_scale      <= RST_REAR_SCL;
		end else if (wr_en) begin
			unique case (idx)
			RI_MAX_LIN:   cfg.max_linear_speed    <= pwdata[14:0];
			RI_MAX_TURN:  cfg.max_turn_rate       <= pwdata[14:0];
			RI_LIN_ACC:   cfg.linear_accel_limit  <= pwdata[15:0];
			RI_ANG_ACC:   cfg.angular_accel_limit <= pwdata[15:0];
			RI_RPM_LIMIT: cfg.rpm_limit           <= pwdata[14:0];
			RI_TRACK:     cfg.track_width_mm      <= pwdata[11:0];
			RI_FRONT_SCL: cfg.front_rpm_scale     <= pwdata[20:0];
			RI_REAR_SCL:  cfg.rear_rpm_scale      <= pwdata[20:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
		RI_MAX_LIN:   prdata = 32'(cfg.max_linear_speed);
		RI_MAX_TURN:  prdata = 32'(cfg.max_turn_rate);
		RI_LIN_ACC:   prdata = 32'(cfg.linear_accel_limit);
		RI_ANG_ACC:   prdata = 32'(cfg.angular_accel_limit);
		RI_RPM_LIMIT: prdata = 32'(cfg.rpm_limit);
		RI_TRACK:     prdata = 32'(cfg.track_width_mm);
		RI_FRONT_SCL: prdata = 32'(cfg.front_rpm_scale);
		RI_REAR_SCL:  prdata = 32'(cfg.rear_rpm_scale);
		endcase
	end

endmodule

[rtl/slew_limited_diff_drive_rpm.sv]
// A tick beat gives its wheel-speed beat at the end of its program; a command beat
// gives none. The next beat is taken only once the current program has finished.
// A tick runs 17 microprogram steps on one shared 31x31 multiplier; a result still
// waiting for the receiver holds the last step.
// Reset (arst_n low, asynchronous) clears targets, velocities, the command timer and all
// handshake state, and loads the register defaults; there is no clearing pass.
module slew_limited_diff_drive_rpm
	import sldd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	sldd_item_if.sink         item,
	sldd_rpm_if.source        speeds
);

	sldd_cfg_t cfg;

	sldd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer state. The block takes one beat at a time: the input is ready whenever the
	// microprogram is not running, even while a finished result still waits in the output
	// register.
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	uword_t          uw;

	// The accepted beat.
	logic        mode_q;
	logic [15:0] lcmd_q;
	logic [15:0] acmd_q;
	logic [19:0] dt_q;

	// Architectural state, two's complement.
	logic [15:0] tgt_lin_q;
	logic [15:0] tgt_ang_q;
	logic [15:0] cur_lin_q;
	logic [15:0] cur_ang_q;
	logic [20:0] timer_q;

	// Datapath scratch registers.
	logic [29:0] t0_q;
	logic [29:0] t1_q;
	logic [17:0] half_q;
	logic [16:0] l_mag_q;
	logic [16:0] r_mag_q;
	logic        l_neg_q;
	logic        r_neg_q;
	logic [15:0] fl_q;
	logic [15:0] fr_q;
	logic [15:0] rl_q;
	logic [15:0] rr_q;

	// Output register.
	logic        out_valid_q;
	logic [15:0] out_fl_q;
	logic [15:0] out_fr_q;
	logic [15:0] out_rl_q;
	logic [15:0] out_rr_q;

	// The shared multiplier; its product is registered and used by the following step.
	logic [30:0] mul_a;
	logic [30:0] mul_b;
	logic [61:0] prod_q;

	logic stall;
	logic jump;
	logic deliver;

	assign uw      = ucode(pc_q);
	assign stall   = uw.emit && out_valid_q && !speeds.ready;
	assign jump    = (uw.jmp == JMP_IF_CMD) && !mode_q;
	assign deliver = busy_q && uw.emit && !stall;

	assign item.ready = !busy_q;

	assign speeds.valid   = out_valid_q;
	assign speeds.fl_crpm = out_fl_q;
	assign speeds.fr_crpm = out_fr_q;
	assign speeds.rl_crpm = out_rl_q;
	assign speeds.rr_crpm = out_rr_q;

	// Symmetric clamp of a signed command to +-lim.
	function automatic logic [15:0] clamp_cmd(input logic [15:0] x, input logic [14:0] lim);
		logic signed [16:0] xs;
		logic signed [16:0] ls;
		xs = $signed({x[15], x});
		ls = $signed({2'b00, lim});
		if (xs > ls) begin
			return {1'b0, lim};
		end else if (xs < -ls) begin
			return 16'(-ls);
		end
		return x;
	endfunction

	function automatic logic within_lim(input logic [15:0] v, input logic [14:0] lim);
		logic signed [16:0] vs;
		logic signed [16:0] ls;
		vs = $signed({v[15], v});
		ls = $signed({2'b00, lim});
		return (vs <= ls) && (vs >= -ls);
	endfunction

	// Magnitude of the current angular velocity; -32768 becomes 32768.
	logic [15:0] ang_mag;
	assign ang_mag = cur_ang_q[15] ? (~cur_ang_q + 16'd1) : cur_ang_q;

	always_comb begin
		unique case (uw.a)
		OPA_NONE:    mul_a = '0;
		OPA_LIN_ACC: mul_a = 31'(cfg.linear_accel_limit);
		OPA_ANG_ACC: mul_a = 31'(cfg.angular_accel_limit);
		OPA_T0:      mul_a = 31'(t0_q);
		OPA_T1:      mul_a = 31'(t1_q);
		OPA_ANG_MAG: mul_a = 31'(ang_mag);
		OPA_L_MAG:   mul_a = 31'(l_mag_q);
		OPA_R_MAG:   mul_a = 31'(r_mag_q);
		endcase
	end

	always_comb begin
		unique case (uw.b)
		OPB_NONE:   mul_b = '0;
		OPB_DT:     mul_b = 31'(dt_q);
		OPB_R15625: mul_b = RECIP_15625;
		OPB_R125:   mul_b = RECIP_125;
		OPB_TRACK:  mul_b = 31'(cfg.track_width_mm);
		OPB_FRONT:  mul_b = 31'(cfg.front_rpm_scale);
		OPB_REAR:   mul_b = 31'(cfg.rear_rpm_scale);
		default:    mul_b = '0;
		endcase
	end

	// Command timer: accumulate and saturate, then compare with the watchdog limit.
	logic [21:0] timer_sum;
	logic [20:0] timer_next;
	logic        tick_timeout;

	assign timer_sum    = {1'b0, timer_q} + 22'(dt_q);
	assign timer_next   = (timer_sum > 22'(TIMER_MAX)) ? TIMER_MAX : timer_sum[20:0];
	assign tick_timeout = timer_next > COMMAND_TIMEOUT_US;

	// Slew limiter, shared by both velocities. The step is floor(accel*dt/1e6), taken from
	// the reciprocal product. The new value always lies between current and target, so it
	// fits in 16 bits.
	logic [15:0] s_cur;
	logic [15:0] s_tgt;
	logic [16:0] s_step;
	logic [16:0] s_err;
	logic [16:0] s_mag;
	logic [17:0] s_move;
	logic [15:0] s_next;

	assign s_cur  = (uw.cap == CAP_SLEW_A) ? cur_ang_q : cur_lin_q;
	assign s_tgt  = (uw.cap == CAP_SLEW_A) ? tgt_ang_q : tgt_lin_q;
	assign s_step = prod_q[60:44];
	assign s_err  = {s_tgt[15], s_tgt} - {s_cur[15], s_cur};
	assign s_mag  = s_err[16] ? (~s_err + 17'd1) : s_err;
	assign s_move = s_err[16] ? ({{2{s_cur[15]}}, s_cur} - {1'b0, s_step})
		: ({{2{s_cur[15]}}, s_cur} + {1'b0, s_step});
	assign s_next = (s_mag > s_step) ? s_move[15:0] : s_tgt;

	// Half-track speed: sign of w times floor(|w|*track/2000).
	logic [16:0] half_mag;
	assign half_mag = prod_q[46:30];

	// Track speeds.
	logic [17:0] left_spd;
	logic [17:0] right_spd;
	assign left_spd  = {{2{cur_lin_q[15]}}, cur_lin_q} - half_q;
	assign right_spd = {{2{cur_lin_q[15]}}, cur_lin_q} + half_q;

	// Wheel speed: floor(|speed|*scale/65536), clamped, with the track's sign restored.
	// Rounding the magnitude down and then negating truncates toward zero.
	logic [21:0] w_mag;
	logic [14:0] w_clamped;
	logic        w_neg;
	logic [15:0] w_val;

	assign w_mag     = prod_q[37:16];
	assign w_clamped = (w_mag > 22'(cfg.rpm_limit)) ? cfg.rpm_limit : w_mag[14:0];
	assign w_neg     = (uw.cap == CAP_FL || uw.cap == CAP_RL) ? l_neg_q : r_neg_q;
	assign w_val     = w_neg ? (~{1'b0, w_clamped} + 16'd1) : {1'b0, w_clamped};

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			tgt_lin_q   <= '0;
			tgt_ang_q   <= '0;
			cur_lin_q   <= '0;
			cur_ang_q   <= '0;
			timer_q     <= '0;
		end else begin
			if (!busy_q) begin
				if (item.valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else if (jump) begin
				pc_q <= uw.target;
			end else if (uw.last) begin
				if (!stall) begin
					busy_q <= 1'b0;
				end
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end

			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (speeds.ready) begin
				out_valid_q <= 1'b0;
			end

			if (busy_q) begin
				unique case (uw.cap)
				CAP_TICK: begin
					timer_q <= timer_next;
					if (tick_timeout) begin
						tgt_lin_q <= '0;
						tgt_ang_q <= '0;
					end
				end
				CAP_CMD: begin
					tgt_lin_q <= clamp_cmd(lcmd_q, cfg.max_linear_speed);
					tgt_ang_q <= clamp_cmd(acmd_q, cfg.max_turn_rate);
					timer_q   <= '0;
				end
				CAP_SLEW_L: cur_lin_q <= s_next;
				CAP_SLEW_A: cur_ang_q <= s_next;
				default: ;
				endcase
			end
		end
	end

	// Payload and scratch registers.
	always_ff @(posedge clk) begin
		prod_q <= {31'b0, mul_a} * {31'b0, mul_b};

		if (item.valid && !busy_q) begin
			mode_q <= item.mode;
			lcmd_q <= item.linear_cmd;
			acmd_q <= item.angular_cmd;
			dt_q   <= item.elapsed_us;
		end

		if (busy_q) begin
			unique case (uw.cap)
			CAP_Y0: t0_q <= prod_q[35:6];
			CAP_Y1: t1_q <= prod_q[35:6];
			CAP_Z:  t0_q <= 30'(prod_q[26:4]);
			CAP_HALF: begin
				half_q <= cur_ang_q[15] ? (~{1'b0, half_mag} + 18'd1) : {1'b0, half_mag};
			end
			CAP_LR: begin
				l_neg_q <= left_spd[17];
				r_neg_q <= right_spd[17];
				l_mag_q <= left_spd[17] ? 17'(~left_spd + 18'd1) : left_spd[16:0];
				r_mag_q <= right_spd[17] ? 17'(~right_spd + 18'd1) : right_spd[16:0];
			end
			CAP_FL: fl_q <= w_val;
			CAP_FR: fr_q <= w_val;
			CAP_RL: rl_q <= w_val;
			CAP_RR: rr_q <= w_val;
			default: ;
			endcase
		end

		if (deliver) begin
			out_fl_q <= fl_q;
			out_fr_q <= fr_q;
			out_rl_q <= rl_q;
			out_rr_q <= rr_q;
		end
	end

	// A result only appears at the end of a tick's program.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(deliver))
		else $error("result raised without an emit step");

	// The step counter never runs off the end of the microprogram.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < PC_W'(UC_DEPTH)))
		else $error("step counter outside microprogram");

	// A watchdog expiry zeroes both targets before the slew steps read them.
	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uw.cap == CAP_TICK && tick_timeout) |=> (tgt_lin_q == '0 && tgt_ang_q == '0))
		else $error("timeout did not clear targets");

	// A command program never produces a result.
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !mode_q) |-> !uw.emit)
		else $error("command reached the emit step");

	// A wheel-speed result respects the clamp whenever valid rises.
	a_rpm_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (within_lim(out_fl_q, cfg.rpm_limit)
			&& within_lim(out_fr_q, cfg.rpm_limit) && within_lim(out_rl_q, cfg.rpm_limit)
			&& within_lim(out_rr_q, cfg.rpm_limit)))
		else $error("wheel speed beyond rpm limit");

endmodule

[dv/slew_limited_diff_drive_rpm_tb.sv]
module slew_limited_diff_drive_rpm_tb
	import sldd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Input beat kinds on the mode field.
	localparam logic MODE_CMD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// The settle wait outlasts a tick beat's program in the block, so it is enough to
	// let a trailing command beat retire before a register write.
	localparam int SETTLE_CYCLES = 24;
	// The watchdog limit is far above the longest legitimate quiet stretch: the long
	// receiver hold-off below, or a sender gap stacked on a receiver stall.
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 300;

	typedef struct {
		logic signed [15:0] fl;
		logic signed [15:0] fr;
		logic signed [15:0] rl;
		logic signed [15:0] rr;
	} wheel_rpm_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sldd_item_if item_bus();
	sldd_rpm_if  rpm_bus();

	slew_limited_diff_drive_rpm dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.item   (item_bus),
		.speeds (rpm_bus)
	);

	always #10 clk = ~clk;

	// Shadow copy of the block: its registers and its motion state.
	sldd_cfg_t          drive_cfg;
	logic signed [15:0] tgt_lin;
	logic signed [15:0] tgt_ang;
	logic signed [15:0] cur_lin;
	logic signed [15:0] cur_ang;
	logic [20:0]        cmd_age_us;

	// Wheel speeds predicted for accepted tick beats, oldest first.
	wheel_rpm_t expected_rpms[$];

	int mismatches    = 0;
	int stall_cycles  = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;

	function automatic longint clamp_sym(input longint x, input longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	// Move one velocity toward its target by the step the acceleration allows over dt.
	function automatic logic signed [15:0] slew_toward(input logic signed [15:0] cur,
			input logic signed [15:0] tgt, input logic [15:0] accel, input logic [19:0] dt);
		longint step;
		longint err;
		longint mag;
		step = (longint'(accel) * longint'(dt)) / 1000000;
		err  = longint'(tgt) - longint'(cur);
		mag  = (err < 0) ? -err : err;
		if (mag > step)
			return 16'((err > 0) ? longint'(cur) + step : longint'(cur) - step);
		return tgt;
	endfunction

	// Track speed in mm/s scaled by a Q16 factor to centi-RPM, truncated toward zero.
	function automatic logic signed [15:0] wheel_rpm(input longint speed,
			input logic [20:0] scale);
		longint r;
		r = (speed * longint'(scale)) / 65536;
		return 16'(clamp_sym(r, longint'(drive_cfg.rpm_limit)));
	endfunction

	function automatic void reset_drive_model();
		drive_cfg.max_linear_speed    = RST_MAX_LIN;
		drive_cfg.max_turn_rate       = RST_MAX_TURN;
		drive_cfg.linear_accel_limit  = RST_LIN_ACC;
		drive_cfg.angular_accel_limit = RST_ANG_ACC;
		drive_cfg.rpm_limit           = RST_RPM_LIMIT;
		drive_cfg.track_width_mm      = RST_TRACK;
		drive_cfg.front_rpm_scale     = RST_FRONT_SCL;
		drive_cfg.rear_rpm_scale      = RST_REAR_SCL;
		tgt_lin    = '0;
		tgt_ang    = '0;
		cur_lin    = '0;
		cur_ang    = '0;
		cmd_age_us = '0;
	endfunction

	// Apply one accepted input beat to the shadow state. A tick queues the four wheel
	// speeds it must produce; a command only latches clamped targets.
	function automatic void predict_wheel_speeds(input logic mode_i,
			input logic signed [15:0] lin, input logic signed [15:0] ang,
			input logic [19:0] dt);
		int unsigned age;
		longint      half;
		longint      left_mm;
		longint      right_mm;
		wheel_rpm_t  w;
		if (mode_i == MODE_CMD) begin
			tgt_lin    = 16'(clamp_sym(lin, drive_cfg.max_linear_speed));
			tgt_ang    = 16'(clamp_sym(ang, drive_cfg.max_turn_rate));
			cmd_age_us = '0;
			return;
		end
		// The command age saturates rather than wrapping, so a stale command stays stale.
		age = cmd_age_us + dt;
		cmd_age_us = (age > TIMER_MAX) ? TIMER_MAX : 21'(age);
		if (cmd_age_us > COMMAND_TIMEOUT_US) begin
			tgt_lin = '0;
			tgt_ang = '0;
		end
		cur_lin = slew_toward(cur_lin, tgt_lin, drive_cfg.linear_accel_limit, dt);
		cur_ang = slew_toward(cur_ang, tgt_ang, drive_cfg.angular_accel_limit, dt);
		half     = (longint'(cur_ang) * longint'(drive_cfg.track_width_mm)) / 2000;
		left_mm  = longint'(cur_lin) - half;
		right_mm = longint'(cur_lin) + half;
		w.fl = wheel_rpm(left_mm, drive_cfg.front_rpm_scale);
		w.fr = wheel_rpm(right_mm, drive_cfg.front_rpm_scale);
		w.rl = wheel_rpm(left_mm, drive_cfg.rear_rpm_scale);
		w.rr = wheel_rpm(right_mm, drive_cfg.rear_rpm_scale);
		expected_rpms.push_back(w);
	endfunction

	// APB write: setup phase, then access phase; the register takes the value at the
	// rising edge where the access phase meets pready. Only the register width is kept.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
		RI_MAX_LIN:   drive_cfg.max_linear_speed    = data[14:0];
		RI_MAX_TURN:  drive_cfg.max_turn_rate       = data[14:0];
		RI_LIN_ACC:   drive_cfg.linear_accel_limit  = data[15:0];
		RI_ANG_ACC:   drive_cfg.angular_accel_limit = data[15:0];
		RI_RPM_LIMIT: drive_cfg.rpm_limit           = data[14:0];
		RI_TRACK:     drive_cfg.track_width_mm      = data[11:0];
		RI_FRONT_SCL: drive_cfg.front_rpm_scale     = data[20:0];
		RI_REAR_SCL:  drive_cfg.rear_rpm_scale      = data[20:0];
		default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one input beat. Idle cycles are inserted first at the current sender rate;
	// valid is assigned once per falling edge, so back-to-back beats keep it high.
	task automatic offer_beat(input logic mode_i, input logic signed [15:0] lin,
			input logic signed [15:0] ang, input logic [19:0] dt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.mode        <= mode_i;
		item_bus.linear_cmd  <= lin;
		item_bus.angular_cmd <= ang;
		item_bus.elapsed_us  <= dt;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		predict_wheel_speeds(mode_i, lin, ang, dt);
	endtask

	// Stop offering, wait for every predicted beat, then let a trailing command retire.
	task automatic drain();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (expected_rpms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Tick interval mix: mostly typical timer periods, with short intervals that often move
	// nothing, zero, and the full field range, which can trip the command timeout at once.
	function automatic logic [19:0] pick_dt();
		case ($urandom_range(9))
		0: return 20'($urandom_range(0, 999));
		1: return 20'($urandom());
		2: return 20'($urandom_range(0, 3));
		default: return 20'($urandom_range(1000, 150000));
		endcase
	endfunction

	function automatic logic [31:0] with_noise(input logic [31:0] v, input int width);
		if ($urandom_range(3) == 0)
			return v | ($urandom() << width);
		return v;
	endfunction

	function automatic logic signed [15:0] pick_cmd(input logic [14:0] lim);
		int span;
		if ($urandom_range(7) == 0)
			return 16'($urandom());
		span = int'(lim) + 100;
		if (span > 32767)
			span = 32767;
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Reset configuration: drive a command into both clamps, creep with steps too small
	// to move, ramp toward the targets, cross the one second timeout by a single
	// microsecond, and saturate the command age.
	task automatic test_directed();
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd0);
		offer_beat(MODE_CMD, 16'sh7FFF, 16'sh8000, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd1);
		offer_beat(MODE_TICK, 16'shFFFF, 16'shFFFF, 20'd999998);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd1);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd1);
		offer_beat(MODE_CMD, 16'sh8000, 16'sh7FFF, 20'hFFFFF);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd600000);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd600000);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd600000);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'hFFFFF);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'hFFFFF);
		offer_beat(MODE_CMD, 16'sd300, -16'sd400, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'hFFFFF);
		offer_beat(MODE_CMD, 16'sd1000, 16'sd2000, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd400000);
		drain();
	endtask

	// Register extremes. Zero acceleration freezes the current motion and a zero track
	// width gives both sides the linear speed; then zero clamps everywhere; then every
	// register written with all ones so that only its own width survives.
	task automatic test_config_extremes();
		write_reg(RI_LIN_ACC, 32'd0);
		write_reg(RI_ANG_ACC, 32'd0);
		write_reg(RI_TRACK, 32'd0);
		offer_beat(MODE_CMD, -16'sd700, 16'sd900, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd999999);
		drain();
		write_reg(RI_MAX_LIN, 32'd0);
		write_reg(RI_MAX_TURN, 32'd0);
		write_reg(RI_RPM_LIMIT, 32'd0);
		write_reg(RI_FRONT_SCL, 32'd0);
		write_reg(RI_REAR_SCL, 32'd0);
		offer_beat(MODE_CMD, 16'sh7FFF, 16'sh8000, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd500000);
		drain();
		write_reg(RI_MAX_LIN, 32'hFFFF_FFFF);
		write_reg(RI_MAX_TURN, 32'hFFFF_FFFF);
		write_reg(RI_LIN_ACC, 32'hFFFF_FFFF);
		write_reg(RI_ANG_ACC, 32'hFFFF_FFFF);
		write_reg(RI_RPM_LIMIT, 32'hFFFF_FFFF);
		write_reg(RI_TRACK, 32'hFFFF_FFFF);
		write_reg(RI_FRONT_SCL, 32'hFFFF_FFFF);
		write_reg(RI_REAR_SCL, 32'hFFFF_FFFF);
		offer_beat(MODE_CMD, 16'sh7FFF, 16'sh8000, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd999999);
		offer_beat(MODE_CMD, 16'sh8000, 16'sh7FFF, 20'd0);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd999999);
		offer_beat(MODE_TICK, 16'sd0, 16'sd0, 20'd999999);
		drain();
	endtask

	// The receiver refuses everything for a long stretch while the sender keeps
	// offering ticks, so the result stage fills and the input must stall.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b1;
		offer_beat(MODE_CMD, 16'sd250, -16'sd800, 20'd0);
		repeat (12)
			offer_beat(MODE_TICK, 16'($urandom()), 16'($urandom()), pick_dt());
		drain();
	endtask

	task automatic shuffle_limits();
		logic [31:0] v;
		v = ($urandom_range(7) == 0) ? $urandom_range(0, 32767) : $urandom_range(100, 3000);
		write_reg(RI_MAX_LIN, with_noise(v, 15));
		v = ($urandom_range(7) == 0) ? $urandom_range(0, 32767) : $urandom_range(100, 6000);
		write_reg(RI_MAX_TURN, with_noise(v, 15));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(50, 5000);
		write_reg(RI_LIN_ACC, with_noise(v, 16));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(50, 8000);
		write_reg(RI_ANG_ACC, with_noise(v, 16));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 32767) : $urandom_range(2000, 20000);
		write_reg(RI_RPM_LIMIT, with_noise(v, 15));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 4095) : $urandom_range(200, 900);
		write_reg(RI_TRACK, with_noise(v, 12));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 2097151)
			: $urandom_range(200000, 1200000);
		write_reg(RI_FRONT_SCL, with_noise(v, 21));
		v = ($urandom_range(3) == 0) ? $urandom_range(0, 2097151)
			: $urandom_range(200000, 1200000);
		write_reg(RI_REAR_SCL, with_noise(v, 21));
	endtask

	// Mostly a command followed by a run of ticks, as a motion planner would send them;
	// some runs lack the command, so targets time out and decay toward zero.
	task automatic run_drive_sequences(input int n_items);
		int sent;
		int ticks;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) != 0) begin
				offer_beat(MODE_CMD, pick_cmd(drive_cfg.max_linear_speed),
					pick_cmd(drive_cfg.max_turn_rate), 20'($urandom()));
				sent++;
			end
			ticks = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
			repeat (ticks) begin
				offer_beat(MODE_TICK, 16'($urandom()), 16'($urandom()), pick_dt());
				sent++;
			end
		end
	endtask

	// Four idling phases, each with fresh register values.
	task automatic test_random_phases();
		int send_sched[4];
		int recv_sched[4];
		send_sched = '{0, 69, 0, 28};
		recv_sched = '{0, 0, 69, 28};
		for (int p = 0; p < 4; p++) begin
			shuffle_limits();
			send_idle_pct = send_sched[p];
			stall_pct     = recv_sched[p];
			run_drive_sequences(PHASE_ITEMS);
			drain();
		end
	endtask

	function automatic void check_field(input string name, input logic signed [15:0] want,
			input logic signed [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Every wheel-speed beat is matched against the oldest prediction.
	always @(posedge clk) begin : check_beat
		wheel_rpm_t want;
		if (arst_n && rpm_bus.valid && rpm_bus.ready) begin
			if (expected_rpms.size() == 0) begin
				$error("wheel-speed beat with no tick outstanding");
				mismatches++;
			end else begin
				want = expected_rpms.pop_front();
				check_field("fl_crpm", want.fl, rpm_bus.fl_crpm);
				check_field("fr_crpm", want.fr, rpm_bus.fr_crpm);
				check_field("rl_crpm", want.rl, rpm_bus.rl_crpm);
				check_field("rr_crpm", want.rr, rpm_bus.rr_crpm);
			end
		end
	end

	// Receiver: random stalls at the current rate, or a long hold-off when requested.
	initial begin
		rpm_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rpm_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				rpm_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Count cycles with no beat moving on either channel and no register access.
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (rpm_bus.valid && rpm_bus.ready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		item_bus.valid       = 1'b0;
		item_bus.mode        = MODE_CMD;
		item_bus.linear_cmd  = '0;
		item_bus.angular_cmd = '0;
		item_bus.elapsed_us  = '0;
		reset_drive_model();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_config_extremes();
		test_output_backpressure();
		test_random_phases();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
